// File: sv/rpn_stack_calculator_core_macros.svh
// assertion macros for the stack calculator
// each use samples on clk and is switched off while arst_n is low
`ifndef RPN_STACK_CALCULATOR_CORE_MACROS_SVH
`define RPN_STACK_CALCULATOR_CORE_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rpn_pkg.sv
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_WIDTH);
	localparam int OP_W        = 3;
	localparam int STS_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_POP  = 3'd5
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2,
		STS_DIV_ZERO  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_HOLD
	} state_t;

	// divider response towards the sequencer
	typedef struct packed {
		logic                  done;
		logic [DATA_WIDTH-1:0] quotient;
	} div_rsp_t;

endpackage

// File: sv/rpn_div.sv
module rpn_div
	import rpn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output div_rsp_t              rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic                  neg_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dvs_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH+1:0] diff;

	// magnitudes; the most negative value maps onto its own bit pattern
	assign a_mag = dividend[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - dividend) : dividend;
	assign b_mag = divisor[DATA_WIDTH-1]  ? (DATA_WIDTH'(0) - divisor)  : divisor;

	// restoring step, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_mag;
			dvs_q <= b_mag;
			neg_q <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
		end else if (busy_q) begin
			if (!diff[DATA_WIDTH+1]) begin
				rem_q <= diff[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (DATA_WIDTH'(0) - quo_q) : quo_q;

endmodule

// File: sv/rpn_stack_calculator_core.sv
// push and add/subtract/multiply: each item is accepted in idle, then executed
// pop: result beat loaded into the output register from execute, or from hold once free
// divide: held in the divide state for the one-bit-per-cycle restoring divider
// a new item is accepted only in idle, once the previous item has finished executing
// reset: arst_n clears the stack count, sequencer and output valid; the stack memory
// itself is not cleared and needs no clearing pass, no item is refused after reset
`include "rpn_stack_calculator_core_macros.svh"

module rpn_stack_calculator_core
	import rpn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_WIDTH-1:0] s_tdata,   // [31:0] operand
	input  logic [OP_W-1:0]       s_tuser,   // [2:0] op
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_WIDTH-1:0] m_tdata,   // [31:0] result_value
	output logic [STS_W-1:0]      m_tuser    // [1:0] status
);

	// sequencer state
	state_t state_q;
	state_t state_d;

	// stack count and the captured item
	logic [CNT_W-1:0]      count_q;
	op_t                   op_q;
	logic [DATA_WIDTH-1:0] operand_q;

	// stack memory, one write port and two registered read ports
	logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
	logic [DATA_WIDTH-1:0] top_rd_q;
	logic [DATA_WIDTH-1:0] nxt_rd_q;

	// result waiting for the output register
	logic [DATA_WIDTH-1:0] res_val_q;
	status_t               res_sts_q;

	// output register
	logic                  m_tvalid_q;
	logic [DATA_WIDTH-1:0] m_tdata_q;
	logic [STS_W-1:0]      m_tuser_q;

	// stack pointers; a full stack wraps the free slot to zero, which is never written
	logic [PTR_W-1:0] ptr_free;
	logic [PTR_W-1:0] ptr_top;
	logic [PTR_W-1:0] ptr_nxt;

	logic accept;
	logic out_free;
	logic full;
	logic lt2;

	// arithmetic on the two top entries, second-from-top is the left operand
	logic [DATA_WIDTH-1:0] sum;
	logic [DATA_WIDTH-1:0] dif;
	logic [DATA_WIDTH-1:0] prod;

	// execute-cycle decode
	logic                  ex_we;
	logic [PTR_W-1:0]      ex_waddr;
	logic [DATA_WIDTH-1:0] ex_wdata;
	logic                  ex_inc;
	logic                  ex_dec;
	logic                  ex_res;
	logic [DATA_WIDTH-1:0] ex_res_val;
	status_t               ex_res_sts;
	logic                  ex_div;

	// sequencer outputs
	logic                  mem_we;
	logic [PTR_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic                  div_start;
	logic                  out_load;
	logic                  res_hold;

	div_rsp_t div_rsp;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign ptr_free = count_q[PTR_W-1:0];
	assign ptr_top  = count_q[PTR_W-1:0] - PTR_W'(1);
	assign ptr_nxt  = count_q[PTR_W-1:0] - PTR_W'(2);

	assign full = (count_q == CNT_W'(STACK_DEPTH));
	assign lt2  = (count_q < CNT_W'(2));

	assign sum  = nxt_rd_q + top_rd_q;
	assign dif  = nxt_rd_q - top_rd_q;
	assign prod = nxt_rd_q * top_rd_q;

	// single iterative divider, used only by divide
	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nxt_rd_q),
		.divisor  (top_rd_q),
		.rsp      (div_rsp)
	);

	// what the captured item does, given the entries read on accept
	always_comb begin
		ex_we      = 1'b0;
		ex_waddr   = ptr_nxt;
		ex_wdata   = sum;
		ex_inc     = 1'b0;
		ex_dec     = 1'b0;
		ex_res     = 1'b0;
		ex_res_val = '0;
		ex_res_sts = STS_OK;
		ex_div     = 1'b0;
		case (op_q)
			OP_PUSH: begin
				if (full) begin
					ex_res     = 1'b1;
					ex_res_sts = STS_OVERFLOW;
				end else begin
					ex_we    = 1'b1;
					ex_waddr = ptr_free;
					ex_wdata = operand_q;
					ex_inc   = 1'b1;
				end
			end
			OP_POP: begin
				ex_res = 1'b1;
				if (count_q == '0) begin
					ex_res_sts = STS_UNDERFLOW;
				end else begin
					ex_res_val = top_rd_q;
					ex_dec     = 1'b1;
				end
			end
			OP_ADD, OP_SUB, OP_MUL: begin
				if (lt2) begin
					ex_res     = 1'b1;
					ex_res_sts = STS_UNDERFLOW;
				end else begin
					ex_we  = 1'b1;
					ex_dec = 1'b1;
					case (op_q)
						OP_ADD:  ex_wdata = sum;
						OP_SUB:  ex_wdata = dif;
						default: ex_wdata = prod;
					endcase
				end
			end
			OP_DIV: begin
				if (lt2) begin
					ex_res     = 1'b1;
					ex_res_sts = STS_UNDERFLOW;
				end else if (top_rd_q == '0) begin
					ex_res     = 1'b1;
					ex_res_sts = STS_DIV_ZERO;
				end else begin
					ex_div = 1'b1;
				end
			end
			default: begin
				// unused op codes leave everything as it is
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (ex_div) begin
					state_d = S_DIV;
				end else if (ex_res && !out_free) begin
					state_d = S_HOLD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_IDLE;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ex_waddr;
		mem_wdata = ex_wdata;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		res_hold  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_EXEC: begin
				mem_we    = ex_we;
				cnt_inc   = ex_inc;
				cnt_dec   = ex_dec;
				div_start = ex_div;
				out_load  = ex_res && out_free;
				res_hold  = ex_res;
			end
			S_DIV: begin
				// quotient replaces the two operands
				if (div_rsp.done) begin
					mem_we    = 1'b1;
					mem_waddr = ptr_nxt;
					mem_wdata = div_rsp.quotient;
					cnt_dec   = 1'b1;
				end
			end
			S_HOLD: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// capture the item on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(s_tuser);
			operand_q <= s_tdata;
		end
	end

	// stack memory: reads issued on accept, writes land before the next accept
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			top_rd_q <= mem[ptr_top];
			nxt_rd_q <= mem[ptr_nxt];
		end
	end

	// result parked while the output register is still occupied
	always_ff @(posedge clk) begin
		if (res_hold) begin
			res_val_q <= ex_res_val;
			res_sts_q <= ex_res_sts;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_HOLD) begin
				m_tdata_q <= res_val_q;
				m_tuser_q <= res_sts_q;
			end else begin
				m_tdata_q <= ex_res_val;
				m_tuser_q <= ex_res_sts;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks on the sequencer and the stack
	`RPN_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
	`RPN_ASSERT_IMP(a_we_state, mem_we, state_q == S_EXEC || state_q == S_DIV, "stack write outside execute")
	`RPN_ASSERT_IMP(a_div_done_state, div_rsp.done, state_q == S_DIV, "divider finished while not waiting")
	`RPN_ASSERT_NXT(a_push_count, state_q == S_EXEC && op_q == OP_PUSH && !full, count_q == $past(count_q) + CNT_W'(1), "push did not grow the stack")

endmodule
